@@ rtl/tslc_pkg.sv @@
// Shared types and constants for the triangle scanline coverage test.
package tslc_pkg;

  // Default coordinate width of vertices, rows and columns.
  localparam int COORD_BITS_DEF = 16;

  // Number of triangle edges.
  localparam int NUM_EDGES = 3;

  // Configuration register index width and register indexes.
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_A_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_A_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_B_X = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_B_Y = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_C_X = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_C_Y = 3'd5;

  // Operation code of an input item.
  typedef enum logic {
    OP_ROW   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Per-edge classification and side flags.
  typedef struct packed {
    logic horiz;   // edge is horizontal
    logic vert;    // edge is vertical
    logic vleft;   // vertical edge: centroid lies left of or on it
    logic sleft;   // sloped edge: centroid lies strictly left of it
    logic hpass;   // horizontal edge: current row is on the centroid side
    logic dy_pos;  // edge runs toward larger y
  } edge_ctl_t;

endpackage

@@ rtl/tslc_setup.sv @@
// Vertex registers, current row and the per-edge terms derived from them.
module tslc_setup #(
  parameter int COORD_BITS = tslc_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [tslc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_data,
  input  logic                                  row_wr,
  input  logic signed [COORD_BITS-1:0]          row_val,
  output logic signed [COORD_BITS-1:0]          cur_row,
  output logic signed [COORD_BITS-1:0]          vtx_x [tslc_pkg::NUM_EDGES],
  output logic signed [COORD_BITS:0]            edge_dy [tslc_pkg::NUM_EDGES],
  output logic signed [2*COORD_BITS+1:0]        row_term [tslc_pkg::NUM_EDGES],
  output tslc_pkg::edge_ctl_t                   edge_ctl [tslc_pkg::NUM_EDGES],
  output logic                                  degen
);
  import tslc_pkg::*;

  localparam int DW = COORD_BITS + 1;      // vertex difference
  localparam int SW = COORD_BITS + 2;      // three-fold sums
  localparam int TW = COORD_BITS + 3;      // centroid offset from a vertex
  localparam int PW = 2 * COORD_BITS + 2;  // row term product
  localparam int QW = TW + DW;             // centroid edge products
  localparam int EW = QW + 1;              // centroid edge function

  logic signed [COORD_BITS-1:0] vx_r [NUM_EDGES];
  logic signed [COORD_BITS-1:0] vy_r [NUM_EDGES];
  logic signed [COORD_BITS-1:0] cur_row_r;
  logic signed [SW-1:0]         sx3;
  logic signed [SW-1:0]         sy3;

  // Vertex registers, written from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_EDGES; i++) begin
        vx_r[i] <= '0;
        vy_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_A_X: vx_r[0] <= cfg_data;
        REG_A_Y: vy_r[0] <= cfg_data;
        REG_B_X: vx_r[1] <= cfg_data;
        REG_B_Y: vy_r[1] <= cfg_data;
        REG_C_X: vx_r[2] <= cfg_data;
        REG_C_Y: vy_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Current row, set by a row select leaving the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
    end else if (row_wr) begin
      cur_row_r <= row_val;
    end
  end

  // Three times the centroid.
  assign sx3 = SW'(vx_r[0]) + SW'(vx_r[1]) + SW'(vx_r[2]);
  assign sy3 = SW'(vy_r[0]) + SW'(vy_r[1]) + SW'(vy_r[2]);

  // Two vertices coinciding make every query answer outside.
  assign degen = ((vx_r[0] == vx_r[1]) && (vy_r[0] == vy_r[1])) ||
                 ((vx_r[1] == vx_r[2]) && (vy_r[1] == vy_r[2])) ||
                 ((vx_r[2] == vx_r[0]) && (vy_r[2] == vy_r[0]));

  assign cur_row = cur_row_r;

  for (genvar gi = 0; gi < NUM_EDGES; gi++) begin : g_edge
    localparam int GJ = (gi + 1) % NUM_EDGES;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] rowd;
    logic signed [SW-1:0] tx3;
    logic signed [SW-1:0] ty3;
    logic signed [TW-1:0] ox;
    logic signed [TW-1:0] oy;
    logic signed [EW-1:0] e3;
    logic                 dy_pos;
    logic                 habove;
    logic                 hpass_nxt;
    logic                 sleft_nxt;
    logic signed [QW-1:0] pa_r;
    logic signed [QW-1:0] pb_r;
    logic                 sleft_r;
    logic                 hpass_r;
    logic signed [PW-1:0] row_term_r;

    // Edge direction and centroid offsets from the start vertex.
    assign dx     = DW'(vx_r[GJ]) - DW'(vx_r[gi]);
    assign dy     = DW'(vy_r[GJ]) - DW'(vy_r[gi]);
    assign rowd   = DW'(cur_row_r) - DW'(vy_r[gi]);
    assign tx3    = (SW'(vx_r[gi]) <<< 1) + SW'(vx_r[gi]);
    assign ty3    = (SW'(vy_r[gi]) <<< 1) + SW'(vy_r[gi]);
    assign ox     = TW'(sx3) - TW'(tx3);
    assign oy     = TW'(sy3) - TW'(ty3);
    assign dy_pos = (dy > 0);

    // Horizontal edge: the row passes when it lies on the centroid side.
    assign habove    = (sy3 <= ty3);
    assign hpass_nxt = habove ? (cur_row_r <= vy_r[gi]) : (cur_row_r >= vy_r[gi]);

    // Sloped edge: side of the centroid from the registered products.
    assign e3        = EW'(pa_r) - EW'(pb_r);
    assign sleft_nxt = dy_pos ? (e3 < 0) : (e3 > 0);

    // Products and flags, refreshed every cycle from the vertex registers, the current row and the products.
    always_ff @(posedge clk) begin
      pa_r       <= QW'(ox) * QW'(dy);
      pb_r       <= QW'(dx) * QW'(oy);
      sleft_r    <= sleft_nxt;
      hpass_r    <= hpass_nxt;
      row_term_r <= PW'(dx) * PW'(rowd);
    end

    assign vtx_x[gi]    = vx_r[gi];
    assign edge_dy[gi]  = dy;
    assign row_term[gi] = row_term_r;
    assign edge_ctl[gi] = '{horiz:  (vy_r[gi] == vy_r[GJ]),
                            vert:   (vx_r[gi] == vx_r[GJ]),
                            vleft:  (sx3 <= tx3),
                            sleft:  sleft_r,
                            hpass:  hpass_r,
                            dy_pos: dy_pos};
  end

endmodule

@@ rtl/tslc_query.sv @@
// Query pipeline: input register, edge product register and result register.
module tslc_query #(
  parameter int COORD_BITS = tslc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic signed [COORD_BITS-1:0]      in_coord,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_inside_res,
  output logic                              row_wr,
  output logic signed [COORD_BITS-1:0]      row_val,
  input  logic signed [COORD_BITS-1:0]      vtx_x [tslc_pkg::NUM_EDGES],
  input  logic signed [COORD_BITS:0]        edge_dy [tslc_pkg::NUM_EDGES],
  input  logic signed [2*COORD_BITS+1:0]    row_term [tslc_pkg::NUM_EDGES],
  input  tslc_pkg::edge_ctl_t               edge_ctl [tslc_pkg::NUM_EDGES],
  input  logic                              degen
);
  import tslc_pkg::*;

  localparam int DW = COORD_BITS + 1;      // column offset from a vertex
  localparam int PW = 2 * COORD_BITS + 2;  // column product
  localparam int EW = PW + 1;              // pixel edge function

  logic                         s1_valid_r;
  logic                         s1_op_r;
  logic signed [COORD_BITS-1:0] s1_coord_r;
  logic                         s2_valid_r;
  logic signed [COORD_BITS-1:0] s2_x_r;
  logic signed [PW-1:0]         s2_prod_r [NUM_EDGES];
  logic                         out_valid_r;
  logic                         out_inside_r;
  logic signed [PW-1:0]         prod_nxt [NUM_EDGES];
  logic [NUM_EDGES-1:0]         edge_ok;
  logic                         inside_nxt;
  logic                         out_ready;
  logic                         s2_ready;
  logic                         s1_ready;

  // Each stage moves on when the stage after it is empty or moving on.
  assign out_ready = !out_valid_r || !out_stall;
  assign s2_ready  = !s2_valid_r || out_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_stall  = !s1_ready;

  // A row select takes effect as it leaves the input stage.
  assign row_wr  = s1_valid_r && s2_ready && (s1_op_r == OP_ROW);
  assign row_val = s1_coord_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_op_r    <= in_op;
      s1_coord_r <= in_coord;
    end
  end

  // Column offset times edge dy, one multiplier per edge.
  always_comb begin
    for (int i = 0; i < NUM_EDGES; i++) begin
      prod_nxt[i] = PW'(DW'(s1_coord_r) - DW'(vtx_x[i])) * PW'(edge_dy[i]);
    end
  end

  // Product register; row selects drop out here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r && (s1_op_r == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_x_r    <= s1_coord_r;
      s2_prod_r <= prod_nxt;
    end
  end

  // Per-edge side test against the centroid side.
  always_comb begin
    logic signed [EW-1:0] e;
    logic                 le;
    logic                 ge;
    logic                 vok;
    logic                 sok;
    for (int i = 0; i < NUM_EDGES; i++) begin
      e   = EW'(s2_prod_r[i]) - EW'(row_term[i]);
      le  = edge_ctl[i].dy_pos ? (e <= 0) : (e >= 0);
      ge  = edge_ctl[i].dy_pos ? (e >= 0) : (e <= 0);
      sok = edge_ctl[i].sleft ? le : ge;
      vok = edge_ctl[i].vleft ? (s2_x_r <= vtx_x[i]) : (s2_x_r >= vtx_x[i]);
      if (edge_ctl[i].horiz) begin
        edge_ok[i] = edge_ctl[i].hpass;
      end else if (edge_ctl[i].vert) begin
        edge_ok[i] = vok;
      end else begin
        edge_ok[i] = sok;
      end
    end
  end

  assign inside_nxt = !degen && (&edge_ok);

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_inside_r <= inside_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

endmodule

@@ rtl/triangle_scanline_coverage_test_top.sv @@
// Top level of the triangle scanline coverage test.
//
// Usage: write the six vertex coordinates on the cfg port (index 0..5 for
// A.x, A.y, B.x, B.y, C.x, C.y) while the block is idle. Then send items on
// the in channel: op 0 selects the current row from coord, op 1 asks whether
// column coord on that row lies inside the triangle (boundary included).
// Only op 1 items produce a transfer on the out channel, in item order.
// A transfer happens on either channel when valid is high and stall is low.
// A query goes through the three stages (input register, edge multiplier
// register, result register); the result register drives out_valid.
// Throughput: one item per cycle while out_stall is low. After a vertex
// write, the centroid flags settle via the product, then the flag registers.
// Reset (synchronous, active low) clears the vertices, the row and all
// valid flags; with all vertices equal every query answers outside.
// When the receiver stalls, the result holds; the pipeline keeps taking
// items until its bubbles are filled, then raises in_stall.
module triangle_scanline_coverage_test_top #(
  parameter int COORD_BITS = tslc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [tslc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]             cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic signed [COORD_BITS-1:0]      in_coord,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_inside_res
);
  import tslc_pkg::*;

  logic                         row_wr;
  logic signed [COORD_BITS-1:0] row_val;
  logic signed [COORD_BITS-1:0] cur_row;
  logic signed [COORD_BITS-1:0] vtx_x [NUM_EDGES];
  logic signed [COORD_BITS:0]   edge_dy [NUM_EDGES];
  logic signed [2*COORD_BITS+1:0] row_term [NUM_EDGES];
  edge_ctl_t                    edge_ctl [NUM_EDGES];
  logic                         degen;

  // Vertex state and derived per-edge terms.
  tslc_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .row_wr   (row_wr),
    .row_val  (row_val),
    .cur_row  (cur_row),
    .vtx_x    (vtx_x),
    .edge_dy  (edge_dy),
    .row_term (row_term),
    .edge_ctl (edge_ctl),
    .degen    (degen)
  );

  // Item pipeline.
  tslc_query #(
    .COORD_BITS(COORD_BITS)
  ) u_query (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_coord      (in_coord),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_inside_res(out_inside_res),
    .row_wr        (row_wr),
    .row_val       (row_val),
    .vtx_x         (vtx_x),
    .edge_dy       (edge_dy),
    .row_term      (row_term),
    .edge_ctl      (edge_ctl),
    .degen         (degen)
  );

`ifndef SYNTHESIS
  // A row select leaving the input stage sets the current row.
  a_row_update: assert property (@(posedge clk) disable iff (!rst_n)
    row_wr |=> (cur_row == $past(row_val)))
    else $error("current row not updated by row select");

  // With no result waiting, the pipeline always takes a new item.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
